/* src/mttd_pkg.sv */
// Shared types and constants for the mains-tick time-of-day clock.
// No dependencies; imported by every module of the block.
package mttd_pkg;

  // Field widths
  localparam int HOUR_W   = 5;
  localparam int MINSEC_W = 6;
  localparam int MS_W     = 10;

  // Counting limits and reset values
  localparam int HOURS_PER_DAY = 24;
  localparam int UNITS_PER_MIN = 60;
  localparam int MS_PER_SEC    = 1000;
  localparam int MS_STEP_MAX   = 999;
  localparam int MS_TICK_RST   = 20;
  localparam int HOUR_RST      = 23;
  localparam int MINSEC_RST    = 59;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MS_PER_TICK = 2'd1;

  // Request kind
  localparam logic ACT_TICK   = 1'b0;
  localparam logic ACT_ADJUST = 1'b1;

  // Adjust target
  localparam logic TGT_TIME  = 1'b0;
  localparam logic TGT_ALARM = 1'b1;

  // Adjust unit codes
  typedef enum logic [1:0] {
    UNIT_HOUR   = 2'd0,
    UNIT_MINUTE = 2'd1,
    UNIT_SECOND = 2'd2
  } unit_t;

  // One-step request travelling between neighboring cells
  typedef struct packed {
    logic up;
    logic down;
  } step_t;

endpackage

/* src/mttd_digit_cell.sv */
// One wrap-around digit of an hh:mm:ss chain with carry and borrow.
// Depends on mttd_pkg for step_t.
module mttd_digit_cell #(
  parameter int W   = 6,
  parameter int MOD = 60,
  parameter int RST = 59
) (
  input  logic            clk,
  input  logic            rst_n,
  input  mttd_pkg::step_t step_in,
  output mttd_pkg::step_t step_out,
  output logic [W-1:0]    value_nxt
);
  import mttd_pkg::*;

  logic [W-1:0] value_r;
  logic [W:0]   plus_one;

  assign plus_one = {1'b0, value_r} + {{W{1'b0}}, 1'b1};

  // Step up or down, wrapping and passing the overflow to the next digit
  always_comb begin
    value_nxt     = value_r;
    step_out.up   = 1'b0;
    step_out.down = 1'b0;
    if (step_in.up) begin
      if (plus_one >= (W+1)'(MOD)) begin
        value_nxt   = '0;
        step_out.up = 1'b1;
      end else begin
        value_nxt = plus_one[W-1:0];
      end
    end else if (step_in.down) begin
      if (value_r == '0 || value_r >= W'(MOD)) begin
        value_nxt     = W'(MOD - 1);
        step_out.down = 1'b1;
      end else begin
        value_nxt = value_r - W'(1);
      end
    end
  end

  // Hold the digit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= W'(RST);
    end else begin
      value_r <= value_nxt;
    end
  end

endmodule

/* src/mttd_millis_cell.sv */
// Millisecond accumulator cell: adds the tick step and emits a second carry.
// Depends on mttd_pkg for widths, limits and step_t.
module mttd_millis_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      tick,
  input  logic [mttd_pkg::MS_W-1:0] ms_per_tick,
  output mttd_pkg::step_t           step_out,
  output logic [mttd_pkg::MS_W-1:0] millis_nxt
);
  import mttd_pkg::*;

  logic [MS_W-1:0] millis_r;
  logic [MS_W-1:0] inc;
  logic [MS_W:0]   sum;

  // Clamp the step so one drop of a second always suffices
  assign inc = (ms_per_tick > MS_W'(MS_STEP_MAX)) ? MS_W'(MS_STEP_MAX) : ms_per_tick;
  assign sum = {1'b0, millis_r} + {1'b0, inc};

  always_comb begin
    millis_nxt    = millis_r;
    step_out.up   = 1'b0;
    step_out.down = 1'b0;
    if (tick) begin
      if (sum >= (MS_W+1)'(MS_PER_SEC)) begin
        millis_nxt  = MS_W'(sum - (MS_W+1)'(MS_PER_SEC));
        step_out.up = 1'b1;
      end else begin
        millis_nxt = sum[MS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      millis_r <= '0;
    end else begin
      millis_r <= millis_nxt;
    end
  end

endmodule

/* src/mains_tick_time_of_day_clock_core.sv */
// Top level of the mains-tick time-of-day clock with alarm time.
// Depends on mttd_pkg, mttd_digit_cell and mttd_millis_cell.
//
// Every request (mains tick or manual adjust) returns one result holding the
// full time, alarm time and millisecond count after it; requests may arrive
// in every cycle while in_tready is high. The state is a row of cells
// (milliseconds, seconds, minutes, hours) where each cell passes its carry or
// borrow to the next one within the cycle. Results leave through a two-entry
// output buffer, so input is taken while one result waits; in_tready drops
// only when both entries are held. Configuration writes are always ready.
module mains_tick_time_of_day_clock_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: [0] target, [2:1] unit, [3] step_down, [7:4] zero
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,
  // in_tuser: [0] action
  input  logic                           in_tuser,
  // out_tdata: [4:0] hour_now, [10:5] minute_now, [16:11] second_now,
  // [21:17] alarm_hour, [27:22] alarm_minute, [33:28] alarm_second,
  // [43:34] millis_now, [47:44] zero
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [47:0]                    out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mttd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mttd_pkg::MS_W-1:0]      cfg_data
);
  import mttd_pkg::*;

  localparam int RES_W = 2 * (HOUR_W + 2 * MINSEC_W) + MS_W;

  // Configuration registers
  logic            run_enable_r;
  logic [MS_W-1:0] ms_per_tick_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_enable_r  <= 1'b0;
      ms_per_tick_r <= MS_W'(MS_TICK_RST);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RUN_ENABLE:  run_enable_r  <= cfg_data[0];
        CFG_MS_PER_TICK: ms_per_tick_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode the request
  logic  in_acc;
  logic  is_adj;
  logic  tgt;
  unit_t unit;
  step_t adj_step;
  step_t hs_in [2];
  step_t mn_in [2];
  step_t sc_in [2];

  assign in_acc        = in_tvalid && in_tready;
  assign is_adj        = in_acc && (in_tuser == ACT_ADJUST);
  assign tgt           = in_tdata[0];
  assign unit          = unit_t'(in_tdata[2:1]);
  assign adj_step.up   = !in_tdata[3];
  assign adj_step.down = in_tdata[3];

  // Millisecond cell feeds the running-time seconds
  step_t           ms_carry;
  logic [MS_W-1:0] millis_nxt;

  mttd_millis_cell u_millis (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick        (in_acc && (in_tuser == ACT_TICK) && run_enable_r),
    .ms_per_tick (ms_per_tick_r),
    .step_out    (ms_carry),
    .millis_nxt  (millis_nxt)
  );

  // Two chains of seconds, minutes and hours: time and alarm
  step_t              sc_out [2];
  step_t              mn_out [2];
  logic [MINSEC_W-1:0] sc_nxt [2];
  logic [MINSEC_W-1:0] mn_nxt [2];
  logic [HOUR_W-1:0]   hr_nxt [2];

  for (genvar k = 0; k < 2; k++) begin : g_chain
    logic sel;

    assign sel = is_adj && (tgt == ((k == 0) ? TGT_TIME : TGT_ALARM));

    // Route the adjust step into its cell, or the carry from below
    always_comb begin
      sc_in[k] = '0;
      mn_in[k] = sc_out[k];
      hs_in[k] = mn_out[k];
      if (k == 0) begin
        sc_in[k] = ms_carry;
      end
      if (sel) begin
        case (unit)
          UNIT_SECOND: sc_in[k] = adj_step;
          UNIT_MINUTE: mn_in[k] = adj_step;
          UNIT_HOUR:   hs_in[k] = adj_step;
          default: ;
        endcase
      end
    end

    mttd_digit_cell #(.W(MINSEC_W), .MOD(UNITS_PER_MIN), .RST(MINSEC_RST)) u_sec (
      .clk       (clk),
      .rst_n     (rst_n),
      .step_in   (sc_in[k]),
      .step_out  (sc_out[k]),
      .value_nxt (sc_nxt[k])
    );

    mttd_digit_cell #(.W(MINSEC_W), .MOD(UNITS_PER_MIN), .RST(MINSEC_RST)) u_min (
      .clk       (clk),
      .rst_n     (rst_n),
      .step_in   (mn_in[k]),
      .step_out  (mn_out[k]),
      .value_nxt (mn_nxt[k])
    );

    mttd_digit_cell #(.W(HOUR_W), .MOD(HOURS_PER_DAY), .RST(HOUR_RST)) u_hour (
      .clk       (clk),
      .rst_n     (rst_n),
      .step_in   (hs_in[k]),
      .step_out  (),
      .value_nxt (hr_nxt[k])
    );
  end

  // Result of this request: the state after it
  logic [RES_W-1:0] res;

  assign res = {millis_nxt, sc_nxt[1], mn_nxt[1], hr_nxt[1],
                sc_nxt[0], mn_nxt[0], hr_nxt[0]};

  // Two-entry output buffer
  logic [RES_W-1:0] head_r, head_nxt;
  logic [RES_W-1:0] tail_r, tail_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             out_acc;

  assign out_acc    = out_tvalid && out_tready;
  assign in_tready  = (cnt_r != 2'd2);
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {(48 - RES_W)'(0), head_r};

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    case ({in_acc, out_acc})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          head_nxt = res;
        end else begin
          tail_nxt = res;
        end
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        head_nxt = tail_r;
        cnt_nxt  = cnt_r - 2'd1;
      end
      2'b11: begin
        if (cnt_r == 2'd1) begin
          head_nxt = res;
        end else begin
          head_nxt = tail_r;
          tail_nxt = res;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule
